// ===== rtl/mrb_pkg.sv =====
package mrb_pkg;

    localparam int unsigned DELAY_BITS      = 40;
    localparam int unsigned COEF_FRAC       = 30;
    localparam int unsigned COEFS_PER_MODE  = 7;
    localparam int unsigned LO_BITS         = 16;
    localparam int unsigned KIND_BITS       = 2;
    localparam int unsigned MODE_BITS       = 3;
    localparam int unsigned SEL_BITS        = 3;
    localparam int unsigned SHIFT_BITS      = 5;
    localparam int unsigned K_BITS          = 6;
    localparam int unsigned WADDR_FULL_BITS = MODE_BITS + SEL_BITS;

    localparam logic [KIND_BITS-1:0] KIND_SAMPLE = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_COEF   = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_CLEAR  = 2'd2;

    // coefficient selects, also the step order of one mode
    localparam logic [SEL_BITS-1:0] OP_GAIN = 3'd0;
    localparam logic [SEL_BITS-1:0] OP_B0   = 3'd1;
    localparam logic [SEL_BITS-1:0] OP_B2   = 3'd2;
    localparam logic [SEL_BITS-1:0] OP_A1   = 3'd3;
    localparam logic [SEL_BITS-1:0] OP_A2   = 3'd4;
    localparam logic [SEL_BITS-1:0] OP_RAD  = 3'd5;
    localparam logic [SEL_BITS-1:0] OP_TUBE = 3'd6;

    typedef struct packed {
        logic [DELAY_BITS-1:0] x1;
        logic [DELAY_BITS-1:0] x2;
        logic [DELAY_BITS-1:0] y1;
        logic [DELAY_BITS-1:0] y2;
    } hist_row_t;

endpackage

// ===== rtl/modal_resonator_bank_unit.sv =====
// Bank of MODE_COUNT biquad resonators driven by one excitation stream. Every
// product goes through 40-bit by 16-bit multiplies in two passes, the low
// coefficient half first, then the high half plus the low partial product;
// each mode step forms seven products and waits for the excitation and the
// saturated output before the products that need them. An audio item runs
// through priming, the mode steps, a drain and the output load before the next
// item can be taken; the result then sits in the output register while the next
// item is accepted. A coefficient write is done while idle; a history clear
// sweeps every history row to zero. After reset the block sweeps both memories
// to zero and accepts no item until the sweep is done. Coefficients live in a
// single-port-read memory of 7*MODE_COUNT words; filter history one row per mode.
module modal_resonator_bank_unit #(
    parameter int MODE_COUNT  = 8,
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 32,
    localparam int IN_RAW  = SAMPLE_BITS + mrb_pkg::MODE_BITS + mrb_pkg::SEL_BITS + COEF_BITS,
    localparam int IN_W    = ((IN_RAW + 7) / 8) * 8,
    localparam int OUT_W   = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // sample_in, mode_index, coef_select, coef_value, zero fill
    input  logic [IN_W-1:0]                 s_tdata,
    // kind
    input  logic [mrb_pkg::KIND_BITS-1:0]   s_tuser,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // radiate_out, tube_out, zero fill
    output logic [OUT_W-1:0]                m_tdata,
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [mrb_pkg::SHIFT_BITS-1:0]  cfg_wdata
);

    localparam int DB         = mrb_pkg::DELAY_BITS;
    localparam int CMEM_DEPTH = MODE_COUNT * mrb_pkg::COEFS_PER_MODE;
    localparam int CADDR_W    = $clog2(CMEM_DEPTH);
    localparam int HADDR_W    = (MODE_COUNT > 1) ? $clog2(MODE_COUNT) : 1;
    localparam int HI_W       = COEF_BITS - mrb_pkg::LO_BITS;
    localparam int LO_W       = DB + mrb_pkg::LO_BITS + 1;
    localparam int HP_W       = DB + HI_W;
    localparam int PROD_W     = DB + COEF_BITS;
    localparam int TERM_W     = PROD_W - mrb_pkg::COEF_FRAC;
    localparam int ACC_W      = TERM_W + $clog2(MODE_COUNT) + 2;
    localparam int EXT_W      = ((ACC_W > DB) ? ACC_W : DB) + 1;
    localparam int F_MODE_LO  = SAMPLE_BITS;
    localparam int F_SEL_LO   = F_MODE_LO + mrb_pkg::MODE_BITS;
    localparam int F_COEF_LO  = F_SEL_LO + mrb_pkg::SEL_BITS;

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_CLEAR = 3'd2;
    localparam logic [2:0] ST_PRIME = 3'd3;
    localparam logic [2:0] ST_RUN   = 3'd4;
    localparam logic [2:0] ST_DRAIN = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    localparam logic [HADDR_W-1:0] LAST_MODE = HADDR_W'(MODE_COUNT - 1);
    localparam logic [CADDR_W-1:0] LAST_ADDR = CADDR_W'(CMEM_DEPTH - 1);

    function automatic logic [DB-1:0] sat_delay(input logic [EXT_W-1:0] v);
        logic [EXT_W-DB:0] top;
        top = v[EXT_W-1:DB-1];
        if (&top || ~|top)
            sat_delay = v[DB-1:0];
        else if (v[EXT_W-1])
            sat_delay = {1'b1, {(DB-1){1'b0}}};
        else
            sat_delay = {1'b0, {(DB-1){1'b1}}};
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] sat_sample(input logic [EXT_W-1:0] v);
        logic [EXT_W-SAMPLE_BITS:0] top;
        top = v[EXT_W-1:SAMPLE_BITS-1];
        if (&top || ~|top)
            sat_sample = v[SAMPLE_BITS-1:0];
        else if (v[EXT_W-1])
            sat_sample = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            sat_sample = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    endfunction

    // input fields
    logic [SAMPLE_BITS-1:0]                  in_sample;
    logic [mrb_pkg::MODE_BITS-1:0]           in_mode;
    logic [mrb_pkg::SEL_BITS-1:0]            in_sel;
    logic [COEF_BITS-1:0]                    in_coef;
    logic [mrb_pkg::WADDR_FULL_BITS-1:0]     wr_full;
    logic                                    wr_ok;

    // control
    logic [2:0]                    state_reg, state_next;
    logic [mrb_pkg::SEL_BITS-1:0]  op_reg, op_next;
    logic                          ph_reg, ph_next;
    logic [HADDR_W-1:0]            mode_reg, mode_next;
    logic [CADDR_W-1:0]            caddr_reg, caddr_next;
    logic [CADDR_W-1:0]            clr_reg, clr_next;
    logic                          post_vld_reg, post_vld_next;
    logic [mrb_pkg::SEL_BITS-1:0]  post_op_reg, post_op_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [mrb_pkg::SHIFT_BITS-1:0] nshift_reg;
    logic                          stall;
    logic                          lo_en, prod_en, prime, out_load, take_sample;

    // memories
    logic [COEF_BITS-1:0]          cmem [CMEM_DEPTH];
    logic                          cmem_we, cmem_re;
    logic [CADDR_W-1:0]            cmem_waddr, cmem_raddr;
    logic [COEF_BITS-1:0]          cmem_wdata;
    logic [COEF_BITS-1:0]          coef_q;
    mrb_pkg::hist_row_t            hmem [MODE_COUNT];
    logic                          hmem_we, hmem_re;
    logic [HADDR_W-1:0]            hmem_waddr, hmem_raddr;
    mrb_pkg::hist_row_t            hmem_wdata;
    mrb_pkg::hist_row_t            hist_q;

    // datapath
    logic [SAMPLE_BITS-1:0]        s_reg;
    logic                          last_reg;
    logic [DB-1:0]                 a_op;
    logic [HI_W-1:0]               coef_hi;
    logic [mrb_pkg::LO_BITS-1:0]   coef_lo;
    logic [LO_W-1:0]               lo_prod, lo_reg;
    logic [HP_W-1:0]               hi_prod;
    logic [PROD_W-1:0]             prod_next, prod_reg;
    logic [mrb_pkg::K_BITS-1:0]    k_sel;
    logic signed [PROD_W-1:0]      shifted;
    logic [TERM_W-1:0]             term;
    logic [ACC_W-1:0]              term_a, facc_diff;
    logic [ACC_W-1:0]              facc_reg, rad_reg, tube_reg;
    logic [DB-1:0]                 x_reg, y_reg;
    logic [SAMPLE_BITS-1:0]        rad_out_reg, tube_out_reg;
    logic                          last_out_reg;

    assign in_sample = s_tdata[SAMPLE_BITS-1:0];
    assign in_mode   = s_tdata[F_MODE_LO +: mrb_pkg::MODE_BITS];
    assign in_sel    = s_tdata[F_SEL_LO +: mrb_pkg::SEL_BITS];
    assign in_coef   = s_tdata[F_COEF_LO +: COEF_BITS];

    assign wr_full = ({{mrb_pkg::SEL_BITS{1'b0}}, in_mode} << 3)
                   - {{mrb_pkg::SEL_BITS{1'b0}}, in_mode}
                   + {{mrb_pkg::MODE_BITS{1'b0}}, in_sel};
    assign wr_ok   = (in_sel <= mrb_pkg::OP_TUBE) && (int'(in_mode) < MODE_COUNT);

    assign s_tready = (state_reg == ST_IDLE);
    assign stall    = !ph_reg && (op_reg inside {mrb_pkg::OP_B0, mrb_pkg::OP_RAD})
                      && post_vld_reg;

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        ph_next       = ph_reg;
        mode_next     = mode_reg;
        caddr_next    = caddr_reg;
        clr_next      = clr_reg;
        post_vld_next = 1'b0;
        post_op_next  = post_op_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmem_we       = 1'b0;
        cmem_re       = 1'b0;
        cmem_waddr    = CADDR_W'(wr_full);
        cmem_raddr    = caddr_reg;
        cmem_wdata    = in_coef;
        hmem_we       = 1'b0;
        hmem_re       = 1'b0;
        hmem_waddr    = mode_reg;
        hmem_raddr    = '0;
        hmem_wdata    = '{x1: x_reg, x2: hist_q.x1, y1: y_reg, y2: hist_q.y1};
        lo_en         = 1'b0;
        prod_en       = 1'b0;
        prime         = 1'b0;
        out_load      = 1'b0;
        take_sample   = 1'b0;

        case (state_reg)
            ST_INIT:
            begin
                cmem_we    = 1'b1;
                cmem_waddr = clr_reg;
                cmem_wdata = '0;
                if (clr_reg < CADDR_W'(MODE_COUNT))
                begin
                    hmem_we    = 1'b1;
                    hmem_waddr = clr_reg[HADDR_W-1:0];
                    hmem_wdata = '0;
                end
                if (clr_reg == LAST_ADDR)
                    state_next = ST_IDLE;
                else
                    clr_next = clr_reg + CADDR_W'(1);
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (s_tuser)
                        mrb_pkg::KIND_SAMPLE:
                        begin
                            take_sample = 1'b1;
                            state_next  = ST_PRIME;
                        end
                        mrb_pkg::KIND_COEF:
                            cmem_we = wr_ok;
                        mrb_pkg::KIND_CLEAR:
                        begin
                            mode_next  = '0;
                            state_next = ST_CLEAR;
                        end
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                hmem_we    = 1'b1;
                hmem_wdata = '0;
                if (mode_reg == LAST_MODE)
                    state_next = ST_IDLE;
                else
                    mode_next = mode_reg + HADDR_W'(1);
            end
            ST_PRIME:
            begin
                prime      = 1'b1;
                cmem_re    = 1'b1;
                cmem_raddr = '0;
                caddr_next = CADDR_W'(1);
                hmem_re    = 1'b1;
                mode_next  = '0;
                op_next    = mrb_pkg::OP_GAIN;
                ph_next    = 1'b0;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (!stall)
                begin
                    if (!ph_reg)
                    begin
                        lo_en   = 1'b1;
                        ph_next = 1'b1;
                        // write back history once the new output is known
                        if (op_reg == mrb_pkg::OP_RAD)
                            hmem_we = 1'b1;
                    end
                    else
                    begin
                        prod_en       = 1'b1;
                        post_vld_next = 1'b1;
                        post_op_next  = op_reg;
                        ph_next       = 1'b0;
                        if (!(op_reg == mrb_pkg::OP_TUBE && mode_reg == LAST_MODE))
                        begin
                            cmem_re    = 1'b1;
                            caddr_next = caddr_reg + CADDR_W'(1);
                        end
                        if (op_reg == mrb_pkg::OP_TUBE)
                        begin
                            if (mode_reg == LAST_MODE)
                                state_next = ST_DRAIN;
                            else
                            begin
                                hmem_re    = 1'b1;
                                hmem_raddr = mode_reg + HADDR_W'(1);
                                mode_next  = mode_reg + HADDR_W'(1);
                                op_next    = mrb_pkg::OP_GAIN;
                            end
                        end
                        else
                            op_next = op_reg + mrb_pkg::SEL_BITS'(1);
                    end
                end
            end
            ST_DRAIN:
                state_next = ST_DONE;
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            op_reg       <= mrb_pkg::OP_GAIN;
            ph_reg       <= 1'b0;
            mode_reg     <= '0;
            caddr_reg    <= '0;
            clr_reg      <= '0;
            post_vld_reg <= 1'b0;
            post_op_reg  <= mrb_pkg::OP_GAIN;
            m_tvalid_reg <= 1'b0;
            nshift_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            ph_reg       <= ph_next;
            mode_reg     <= mode_next;
            caddr_reg    <= caddr_next;
            clr_reg      <= clr_next;
            post_vld_reg <= post_vld_next;
            post_op_reg  <= post_op_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we)
                nshift_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmem_we)
            cmem[cmem_waddr] <= cmem_wdata;
        if (cmem_re)
            coef_q <= cmem[cmem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (hmem_we)
            hmem[hmem_waddr] <= hmem_wdata;
        if (hmem_re)
            hist_q <= hmem[hmem_raddr];
    end

    // shared multiplier: low half of the coefficient, then high half plus low
    always_comb
    begin
        case (op_reg)
            mrb_pkg::OP_GAIN: a_op = {{(DB-SAMPLE_BITS){s_reg[SAMPLE_BITS-1]}}, s_reg};
            mrb_pkg::OP_B0:   a_op = x_reg;
            mrb_pkg::OP_B2:   a_op = hist_q.x2;
            mrb_pkg::OP_A1:   a_op = hist_q.y1;
            mrb_pkg::OP_A2:   a_op = hist_q.y2;
            mrb_pkg::OP_RAD:  a_op = y_reg;
            mrb_pkg::OP_TUBE: a_op = y_reg;
            default:          a_op = '0;
        endcase
    end

    assign coef_lo   = coef_q[mrb_pkg::LO_BITS-1:0];
    assign coef_hi   = coef_q[COEF_BITS-1:mrb_pkg::LO_BITS];
    assign lo_prod   = {{(LO_W-DB){a_op[DB-1]}}, a_op}
                     * {{(LO_W-mrb_pkg::LO_BITS){1'b0}}, coef_lo};
    assign hi_prod   = {{HI_W{a_op[DB-1]}}, a_op} * {{DB{coef_hi[HI_W-1]}}, coef_hi};
    assign prod_next = {hi_prod, {mrb_pkg::LO_BITS{1'b0}}}
                     + {{(PROD_W-LO_W){lo_reg[LO_W-1]}}, lo_reg};

    // scale by the fraction bits, plus the configured shift for B0 and B2, floor
    assign k_sel     = (post_op_reg inside {mrb_pkg::OP_B0, mrb_pkg::OP_B2})
                     ? mrb_pkg::K_BITS'(mrb_pkg::COEF_FRAC) + {1'b0, nshift_reg}
                     : mrb_pkg::K_BITS'(mrb_pkg::COEF_FRAC);
    assign shifted   = $signed(prod_reg) >>> k_sel;
    assign term      = shifted[TERM_W-1:0];
    assign term_a    = {{(ACC_W-TERM_W){term[TERM_W-1]}}, term};
    assign facc_diff = facc_reg - term_a;

    always_ff @(posedge clk)
    begin
        if (take_sample)
        begin
            s_reg    <= in_sample;
            last_reg <= s_tlast;
        end
        if (lo_en)
            lo_reg <= lo_prod;
        if (prod_en)
            prod_reg <= prod_next;
        if (prime)
        begin
            rad_reg  <= '0;
            tube_reg <= '0;
        end
        if (post_vld_reg)
        begin
            case (post_op_reg)
                mrb_pkg::OP_GAIN:
                    x_reg <= sat_delay({{(EXT_W-TERM_W){term[TERM_W-1]}}, term});
                mrb_pkg::OP_B0:   facc_reg <= term_a;
                mrb_pkg::OP_B2:   facc_reg <= facc_reg + term_a;
                mrb_pkg::OP_A1:   facc_reg <= facc_diff;
                mrb_pkg::OP_A2:
                    y_reg <= sat_delay({{(EXT_W-ACC_W){facc_diff[ACC_W-1]}}, facc_diff});
                mrb_pkg::OP_RAD:  rad_reg <= rad_reg + term_a;
                mrb_pkg::OP_TUBE: tube_reg <= tube_reg + term_a;
                default:          facc_reg <= facc_reg;
            endcase
        end
        if (out_load)
        begin
            rad_out_reg  <= sat_sample({{(EXT_W-ACC_W){rad_reg[ACC_W-1]}}, rad_reg});
            tube_out_reg <= sat_sample({{(EXT_W-ACC_W){tube_reg[ACC_W-1]}}, tube_reg});
            last_out_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_W-2*SAMPLE_BITS){1'b0}}, tube_out_reg, rad_out_reg};
    assign m_tlast  = last_out_reg;

endmodule

// ===== test/modal_resonator_bank_unit_tb.sv =====
`timescale 1ns / 100ps

module modal_resonator_bank_unit_tb;
    import mrb_pkg::*;

    localparam int MODES         = 8;
    localparam int SAMPLE_W      = 24;
    localparam int COEF_W        = 32;
    localparam int DATA_W        = 64;
    localparam int MIX_W         = 48;
    localparam int HOLD_CYCLES   = 1500;
    localparam int SETTLE_CYCLES = 200;
    localparam int STALL_LIMIT   = 6000;
    localparam int PHASE_ITEMS   = 120;
    localparam int PHASES        = 5;

    localparam logic [KIND_BITS-1:0] KIND_NONE = 2'd3;
    localparam logic [SEL_BITS-1:0]  SEL_NONE  = 3'd7;

    typedef logic signed [79:0] wide_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] radiate;
        logic [SAMPLE_W-1:0] tube;
        logic                last;
    } mix_t;

    class bank_tracker;
        logic [SHIFT_BITS-1:0] frac_shift;
        wide_t                 in_d1[MODES];
        wide_t                 in_d2[MODES];
        wide_t                 out_d1[MODES];
        wide_t                 out_d2[MODES];
        wide_t                 coef[MODES][COEFS_PER_MODE];
        mix_t                  mix_due[$];
        int                    errors;
        int                    checked;

        function new();
            frac_shift = '0;
            errors     = 0;
            checked    = 0;
            clear_history();
            foreach (coef[m, s])
                coef[m][s] = '0;
        endfunction

        function void clear_history();
            foreach (in_d1[m])
            begin
                in_d1[m]  = '0;
                in_d2[m]  = '0;
                out_d1[m] = '0;
                out_d2[m] = '0;
            end
        endfunction

        // floor(a*b / 2^k)
        function wide_t mul_floor(wide_t a, wide_t b, int k);
            wide_t p;
            p = a * b;
            return p >>> k;
        endfunction

        function wide_t clamp(wide_t v, int w);
            wide_t hi;
            hi = (wide_t'(1) <<< (w - 1)) - 1;
            if (v > hi)
                return hi;
            if (v < -hi - 1)
                return -hi - 1;
            return v;
        endfunction

        function void take_item(logic [KIND_BITS-1:0] kind, logic signed [SAMPLE_W-1:0] sample,
                                logic last, logic [MODE_BITS-1:0] mode,
                                logic [SEL_BITS-1:0] sel, logic signed [COEF_W-1:0] value);
            wide_t s;
            wide_t x;
            wide_t y;
            wide_t acc;
            wide_t rad;
            wide_t tube;
            int    nk;
            mix_t  due;
            case (kind)
                KIND_COEF:
                begin
                    if (sel <= OP_TUBE && mode < MODES)
                        coef[mode][sel] = value;
                end
                KIND_CLEAR:
                    clear_history();
                KIND_SAMPLE:
                begin
                    s    = sample;
                    nk   = COEF_FRAC + frac_shift;
                    rad  = '0;
                    tube = '0;
                    for (int m = 0; m < MODES; m++)
                    begin
                        x   = clamp(mul_floor(s, coef[m][OP_GAIN], COEF_FRAC), DELAY_BITS);
                        acc = mul_floor(x, coef[m][OP_B0], nk)
                            + mul_floor(in_d2[m], coef[m][OP_B2], nk)
                            - mul_floor(out_d1[m], coef[m][OP_A1], COEF_FRAC)
                            - mul_floor(out_d2[m], coef[m][OP_A2], COEF_FRAC);
                        y   = clamp(acc, DELAY_BITS);
                        in_d2[m]  = in_d1[m];
                        in_d1[m]  = x;
                        out_d2[m] = out_d1[m];
                        out_d1[m] = y;
                        rad  = rad + mul_floor(y, coef[m][OP_RAD], COEF_FRAC);
                        tube = tube + mul_floor(y, coef[m][OP_TUBE], COEF_FRAC);
                    end
                    rad         = clamp(rad, SAMPLE_W);
                    tube        = clamp(tube, SAMPLE_W);
                    due.radiate = rad[SAMPLE_W-1:0];
                    due.tube    = tube[SAMPLE_W-1:0];
                    due.last    = last;
                    mix_due.push_back(due);
                end
                default: ;
            endcase
        endfunction

        function void check_mix(logic [SAMPLE_W-1:0] radiate, logic [SAMPLE_W-1:0] tube,
                                logic last);
            mix_t due;
            if (mix_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: radiate %h tube %h last %b",
                         $time, radiate, tube, last);
                return;
            end
            due = mix_due.pop_front();
            checked++;
            if (radiate !== due.radiate)
            begin
                errors++;
                $display("%0t: radiate_out expected %h actual %h", $time, due.radiate, radiate);
            end
            if (tube !== due.tube)
            begin
                errors++;
                $display("%0t: tube_out expected %h actual %h", $time, due.tube, tube);
            end
            if (last !== due.last)
            begin
                errors++;
                $display("%0t: block_end_out expected %b actual %b", $time, due.last, last);
            end
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata   = '0;
    logic [KIND_BITS-1:0]  s_tuser   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [MIX_W-1:0]      m_tdata;
    logic                  m_tlast;
    logic                  cfg_we    = 1'b0;
    logic [SHIFT_BITS-1:0] cfg_wdata = '0;

    bank_tracker tracker = new();

    bit steady       = 1'b0;
    bit hold_off_req = 1'b0;
    int n_samples    = 0;
    int n_coefs      = 0;
    int n_clears     = 0;
    int n_ignored    = 0;
    int n_shifts     = 0;

    modal_resonator_bank_unit #(
        .MODE_COUNT  (MODES),
        .SAMPLE_BITS (SAMPLE_W),
        .COEF_BITS   (COEF_W)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin : sink
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                tracker.check_mix(m_tdata[SAMPLE_W-1:0], m_tdata[2*SAMPLE_W-1:SAMPLE_W], m_tlast);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= steady || ($urandom_range(0, 99) >= 9);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("modal_resonator_bank_unit_tb failed");
        $finish;
    end

    function automatic int counted();
        return n_samples + n_coefs + n_clears;
    endfunction

    function automatic logic [COEF_W-1:0] spread(input longint span);
        return COEF_W'(longint'($urandom_range(0, 32'(2 * span))) - span);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 24'h7F_FFFF;
            1: return 24'h80_0000;
            2: return '0;
            3: return SAMPLE_W'($urandom_range(0, 511)) - SAMPLE_W'(256);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic [KIND_BITS-1:0] kind, input logic [SAMPLE_W-1:0] sample,
                             input logic last, input logic [MODE_BITS-1:0] mode,
                             input logic [SEL_BITS-1:0] sel, input logic [COEF_W-1:0] value);
        int gap;
        if (!steady && $urandom_range(0, 99) < 9)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 160) : $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tlast  <= last;
        s_tdata  <= {2'b00, value, sel, mode, sample};
        do
            @(posedge clk);
        while (!s_tready);
        tracker.take_item(kind, sample, last, mode, sel, value);
        case (kind)
            KIND_SAMPLE: n_samples++;
            KIND_COEF:
            begin
                if (sel == SEL_NONE)
                    n_ignored++;
                else
                    n_coefs++;
            end
            KIND_CLEAR: n_clears++;
            default: n_ignored++;
        endcase
    endtask

    task automatic play(input logic [SAMPLE_W-1:0] sample, input logic last);
        send_item(KIND_SAMPLE, sample, last, MODE_BITS'($urandom), SEL_BITS'($urandom), $urandom);
    endtask

    task automatic load(input logic [MODE_BITS-1:0] mode, input logic [SEL_BITS-1:0] sel,
                        input logic [COEF_W-1:0] value);
        send_item(KIND_COEF, SAMPLE_W'($urandom), 1'($urandom), mode, sel, value);
    endtask

    task automatic wipe_history();
        send_item(KIND_CLEAR, SAMPLE_W'($urandom), 1'($urandom), MODE_BITS'($urandom),
                  SEL_BITS'($urandom), $urandom);
    endtask

    task automatic drop_item();
        send_item(KIND_NONE, SAMPLE_W'($urandom), 1'($urandom), MODE_BITS'($urandom),
                  SEL_BITS'($urandom), $urandom);
    endtask

    // stable pole pair: 0.25 <= a2 < 1, |a1| < 1 + a2
    task automatic tune_mode(input logic [MODE_BITS-1:0] mode);
        longint a2;
        longint reach;
        a2    = $urandom_range(32'h1000_0000, 32'h3FF0_0000);
        reach = 64'h4000_0000 + a2 - 64'h0010_0000;
        load(mode, OP_GAIN, spread(64'h4000_0000));
        load(mode, OP_B0, $urandom);
        load(mode, OP_B2, $urandom);
        load(mode, OP_A1, spread(reach));
        load(mode, OP_A2, COEF_W'(a2));
        load(mode, OP_RAD, spread(64'h4000_0000));
        load(mode, OP_TUBE, spread(64'h4000_0000));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.mix_due.size() != 0);
    endtask

    task automatic write_shift(input logic [SHIFT_BITS-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.frac_shift = value;
        n_shifts++;
    endtask

    initial
    begin : stimulus
        int phase;
        int target;
        int pick;
        int run;
        bit hold_done;
        bit paused;
        hold_done = 1'b0;
        paused    = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        write_shift(5'd0);
        load(3'd0, OP_GAIN, 32'h7FFF_FFFF);
        load(3'd0, OP_B0,   32'h4000_0000);
        load(3'd0, OP_B2,   32'hC000_0000);
        load(3'd0, OP_A1,   32'h8000_0000);
        load(3'd0, OP_A2,   32'h3F00_0000);
        load(3'd0, OP_RAD,  32'h4000_0000);
        load(3'd0, OP_TUBE, 32'h8000_0000);
        load(3'd7, OP_GAIN, 32'h8000_0000);
        load(3'd7, OP_B0,   32'h7FFF_FFFF);
        load(3'd7, OP_RAD,  32'h7FFF_FFFF);
        load(3'd3, SEL_NONE, 32'h7FFF_FFFF);
        drop_item();
        play(24'h7F_FFFF, 1'b0);
        play(24'h80_0000, 1'b0);
        play(24'h00_0000, 1'b0);
        play(24'h00_0001, 1'b0);
        play(24'hFF_FFFF, 1'b1);
        wipe_history();
        play(24'h7F_FFFF, 1'b1);
        write_shift(5'd31);
        play(24'h40_0000, 1'b1);

        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 0)
                write_shift(5'd31);
            else if (phase == 2)
                write_shift(5'd0);
            else
                write_shift(SHIFT_BITS'($urandom));
            steady = (phase == PHASES - 1);
            if (phase == 0 || phase == 2)
                for (int m = 0; m < MODES; m++)
                    tune_mode(MODE_BITS'(m));
            target = counted() + PHASE_ITEMS;
            while (counted() < target)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    tune_mode(MODE_BITS'($urandom));
                else if (pick < 15)
                    load(MODE_BITS'($urandom), SEL_BITS'($urandom), $urandom);
                else if (pick < 18)
                    wipe_history();
                else if (pick < 20)
                    drop_item();
                else
                begin
                    if (phase == 1 && !hold_done)
                    begin
                        hold_off_req = 1'b1;
                        hold_done    = 1'b1;
                    end
                    if (phase == 3 && !paused && counted() >= target - PHASE_ITEMS / 2)
                    begin
                        wait_drained();
                        paused = 1'b1;
                    end
                    run = $urandom_range(4, 16);
                    repeat (run - 1) play(pick_sample(), 1'b0);
                    play(pick_sample(), 1'b1);
                end
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d samples, %0d coefficient writes, %0d clears, %0d ignored items",
                 n_samples, n_coefs, n_clears, n_ignored);
        $display("%0d results checked over %0d shift settings, with output hold-off and drain",
                 tracker.checked, n_shifts);
        if (tracker.errors == 0)
            $display("modal_resonator_bank_unit_tb passed");
        else
            $display("modal_resonator_bank_unit_tb failed");
        $finish;
    end

endmodule

// ===== modal_resonator_bank_unit.f =====
rtl/mrb_pkg.sv
rtl/modal_resonator_bank_unit.sv
test/modal_resonator_bank_unit_tb.sv
